[sv/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int BS_W       = 13;
  localparam int BYTES_W    = 16;
  localparam int DIV_W      = 17;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 1'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 7'd64;
  localparam logic [BS_W-1:0]  BS_RESET    = 13'd512;

  typedef struct packed {
    logic               cmd;
    logic [BYTES_W-1:0] byte_count;
    logic [IDX_W-1:0]   block_index;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             block_valid;
    logic [IDX_W-1:0] block_number;
    logic             last;
    logic [CNT_W-1:0] free_blocks;
  } bba_out_t;

endpackage

[sv/bba_ram.sv]
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/bba_div.sv]
`timescale 1ns / 1ps

module bba_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [bba_pkg::DIV_W-1:0] dividend,
  input  logic [bba_pkg::BS_W-1:0]  divisor,
  output logic                    busy,
  output logic [bba_pkg::DIV_W-1:0] quotient
);
  import bba_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

  logic [STEP_W-1:0] step;
  logic [BS_W-1:0]   rem;
  logic [BS_W-1:0]   dvs;
  logic [BS_W:0]     rem_sh;
  logic              q_bit;
  logic [BS_W:0]     rem_sub;

  assign rem_sh  = {rem, quotient[DIV_W-1]};
  assign q_bit   = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIV_W-2:0], q_bit};
      rem      <= q_bit ? rem_sub[BS_W-1:0] : rem_sh[BS_W-1:0];
    end
  end

endmodule

[sv/bitmap_block_allocator.sv]
`timescale 1ns / 1ps
// a count pass reads the first n entries of the used map (n = effective block count);
// an allocate also waits out the block-count divide before it leaves the count pass
// free: count pass, then a read and a write-back of the entry; a bad index, or an
// allocate that places nothing, goes straight from the count pass to the reply
// allocate: count pass, then a read and a check per map entry visited
// one transaction in flight at a time; reset (synchronous): map reads as all free,
// total_blocks 64, block_size 512

module bitmap_block_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bba_pkg::bba_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bba_pkg::bba_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::BS_W-1:0]      cfg_data
);
  import bba_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_COUNT   = 7'b0000010,
    S_FREE_RD = 7'b0000100,
    S_FREE_WB = 7'b0001000,
    S_AL_RD   = 7'b0010000,
    S_AL_CHK  = 7'b0100000,
    S_REPLY   = 7'b1000000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]   total_blocks;
  logic [BS_W-1:0]    block_size;
  logic [CNT_W-1:0]   n_eff;
  logic [BS_W-1:0]    bs_eff;
  logic [DIV_W-1:0]   dividend;

  logic               cmd_q;
  logic [IDX_W-1:0]   idx_q;
  logic [CNT_W-1:0]   cnt_i;
  logic               cnt_pend;
  logic [CNT_W-1:0]   freec;
  logic [CNT_W-1:0]   after;
  logic [CNT_W-1:0]   rem_need;
  logic [1:0]         rep_status;

  logic               div_start;
  logic               div_busy;
  logic [DIV_W-1:0]   need;

  logic [NUM_BLOCKS-1:0] ent_vld;
  logic               vld_q;
  logic [0:0]         ram_q;
  logic               bit_used;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [0:0]         ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;

  logic               out_free;
  logic               emit;
  bba_out_t           emit_data;
  logic               accept;
  logic               cnt_done;

  assign n_eff    = (total_blocks > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : total_blocks;
  assign bs_eff   = (block_size == '0) ? BS_W'(1) : block_size;
  assign dividend = DIV_W'(in_data.byte_count) + DIV_W'(bs_eff) - DIV_W'(1);

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = accept;
  assign out_free  = !out_valid || out_ready;
  assign bit_used  = ram_q[0] & vld_q;
  assign cnt_done  = (cnt_i >= n_eff) && !cnt_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= TOTAL_RESET;
      block_size   <= BS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL_BLOCKS: total_blocks <= cfg_data[CNT_W-1:0];
        CFG_BLOCK_SIZE:   block_size   <= cfg_data;
        default:          ;
      endcase
    end
  end

  bba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (bs_eff),
    .busy     (div_busy),
    .quotient (need)
  );

  bba_ram #(
    .WIDTH (1),
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // map port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cnt_i[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = cnt_i[IDX_W-1:0];
    ram_wdata = 1'b1;
    emit      = 1'b0;
    emit_data = '{status: ST_OK, block_valid: 1'b0, block_number: '0,
                  last: 1'b1, free_blocks: freec};
    unique case (state)
      S_COUNT: begin
        ram_re = cnt_i < n_eff;
      end
      S_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
      end
      S_FREE_WB: begin
        if (out_free) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = 1'b0;
          emit      = 1'b1;
          emit_data.free_blocks = freec + CNT_W'(bit_used);
        end
      end
      S_AL_RD: begin
        ram_re = 1'b1;
      end
      S_AL_CHK: begin
        if (!bit_used && out_free) begin
          ram_we = 1'b1;
          emit   = 1'b1;
          emit_data = '{status: ST_OK, block_valid: 1'b1, block_number: cnt_i[IDX_W-1:0],
                        last: rem_need == CNT_W'(1), free_blocks: after};
        end
      end
      S_REPLY: begin
        if (out_free) begin
          emit = 1'b1;
          emit_data.status = rep_status;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (ram_we) begin
      ent_vld[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      vld_q <= ent_vld[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt_i    <= '0;
      cnt_pend <= 1'b0;
      freec    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= in_data.cmd;
            idx_q    <= in_data.block_index;
            cnt_i    <= '0;
            cnt_pend <= 1'b0;
            freec    <= '0;
            state    <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (cnt_i < n_eff) begin
            cnt_i    <= cnt_i + 1'b1;
            cnt_pend <= 1'b1;
          end else begin
            cnt_pend <= 1'b0;
          end
          if (cnt_pend && !bit_used) begin
            freec <= freec + 1'b1;
          end
          if (cnt_done && (cmd_q == CMD_FREE || !div_busy)) begin
            cnt_i <= '0;
            if (cmd_q == CMD_FREE) begin
              if (CNT_W'(idx_q) >= n_eff) begin
                rep_status <= ST_BAD_INDEX;
                state      <= S_REPLY;
              end else begin
                state <= S_FREE_RD;
              end
            end else if (need == '0) begin
              rep_status <= ST_OK;
              state      <= S_REPLY;
            end else if (need > DIV_W'(freec)) begin
              rep_status <= ST_NO_SPACE;
              state      <= S_REPLY;
            end else begin
              rem_need <= need[CNT_W-1:0];
              after    <= freec - need[CNT_W-1:0];
              state    <= S_AL_RD;
            end
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_WB;
        end
        S_FREE_WB: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_AL_RD: begin
          state <= S_AL_CHK;
        end
        S_AL_CHK: begin
          if (bit_used) begin
            cnt_i <= cnt_i + 1'b1;
            state <= S_AL_RD;
          end else if (out_free) begin
            cnt_i    <= cnt_i + 1'b1;
            rem_need <= rem_need - 1'b1;
            state    <= (rem_need == CNT_W'(1)) ? S_IDLE : S_AL_RD;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_data;
    end
  end

endmodule
